// ----- rtl/asc_pkg.sv -----
// Shared types, constants and helpers for the Ascon-128 AEAD engine.
// No dependencies; imported by asc_round, ascon128_aead_engine and the testbench.
package asc_pkg;

  // five 64-bit sponge lanes, lane 0 in slot 0
  typedef logic [4:0][63:0] lanes_t;

  localparam logic [63:0] ASC_IV = 64'h80400c0600000000;

  // item kinds on the input channel
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_AD    = 2'd1;
  localparam logic [1:0] KIND_MSG   = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SEQ   = 2'd1;
  localparam logic [1:0] STATUS_COUNT = 2'd2;

  // configuration register indexes
  localparam int unsigned  CFG_IDX_W     = 2;
  localparam logic [1:0]   CFG_KEY_HIGH  = 2'd0;
  localparam logic [1:0]   CFG_KEY_LOW   = 2'd1;

  // round counter: full permutation starts at 0, short one at 6, ends at 11
  localparam logic [3:0] RND_FIRST_A = 4'd0;
  localparam logic [3:0] RND_FIRST_B = 4'd6;
  localparam logic [3:0] RND_LAST    = 4'd11;

  localparam logic [3:0] BYTES_FULL = 4'd8;
  localparam logic [3:0] BYTES_MAXL = 4'd7;

  // round constant of round r (0..11): high nibble 15-r, low nibble r
  function automatic logic [7:0] round_const(input logic [3:0] r);
    round_const = {4'hf - r, r};
  endfunction

endpackage

// ----- rtl/asc_round.sv -----
// One Ascon permutation round: constant addition, S-box layer, linear layer.
// Depends on asc_pkg (lanes_t).
module asc_round (
  input  asc_pkg::lanes_t  lanes_in,
  input  logic [7:0]       rc,
  output asc_pkg::lanes_t  lanes_out
);
  import asc_pkg::*;

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  logic [63:0] s0, s1, s2, s3, s4;
  logic [63:0] c0, c1, c2, c3, c4;
  logic [63:0] u0, u1, u2, u3, u4;

  // constant addition and S-box input mixing
  always_comb begin
    s0 = lanes_in[0] ^ lanes_in[4];
    s1 = lanes_in[1];
    s2 = lanes_in[2] ^ {56'd0, rc} ^ lanes_in[1];
    s3 = lanes_in[3];
    s4 = lanes_in[4] ^ lanes_in[3];
  end

  // chi-like nonlinear step
  always_comb begin
    c0 = s0 ^ (~s1 & s2);
    c1 = s1 ^ (~s2 & s3);
    c2 = s2 ^ (~s3 & s4);
    c3 = s3 ^ (~s4 & s0);
    c4 = s4 ^ (~s0 & s1);
  end

  // S-box output mixing
  always_comb begin
    u1 = c1 ^ c0;
    u0 = c0 ^ c4;
    u3 = c3 ^ c2;
    u2 = ~c2;
    u4 = c4;
  end

  // linear diffusion per lane
  always_comb begin
    lanes_out[0] = u0 ^ rotr(u0, 19) ^ rotr(u0, 28);
    lanes_out[1] = u1 ^ rotr(u1, 61) ^ rotr(u1, 39);
    lanes_out[2] = u2 ^ rotr(u2, 1)  ^ rotr(u2, 6);
    lanes_out[3] = u3 ^ rotr(u3, 10) ^ rotr(u3, 17);
    lanes_out[4] = u4 ^ rotr(u4, 7)  ^ rotr(u4, 41);
  end

endmodule

// ----- rtl/ascon128_aead_engine.sv -----
// Ascon-128 AEAD engine: one round unit shared over all rounds under a small sequencer.
// An accepted item runs its rounds and a post step, then its result waits in the done state
// until the output register is free; rejected items skip the rounds. Start and AD items
// give no result. Only one item is in flight: in_stall is high from the accept until the
// item has been retired, also while its result waits for the output register.
// Synchronous active-low reset clears key, lanes, phase and control; no clearing pass.
module ascon128_aead_engine (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [asc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [63:0]                     cfg_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_kind,
  input  logic                            in_decrypt,
  input  logic [63:0]                     in_data_word,
  input  logic [3:0]                      in_byte_count,
  input  logic                            in_last,
  input  logic [63:0]                     in_extra_high,
  input  logic [63:0]                     in_extra_low,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [63:0]                     out_word,
  output logic [3:0]                      out_bytes,
  output logic                            out_final_res,
  output logic [63:0]                     out_tag_high,
  output logic [63:0]                     out_tag_low,
  output logic                            out_tag_match,
  output logic [1:0]                      out_status
);
  import asc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_POST, S_DONE} state_t;
  typedef enum logic [1:0] {PH_IDLE, PH_READY, PH_AD, PH_MSG} phase_t;
  typedef enum logic [1:0] {POST_NONE, POST_START, POST_ADLAST, POST_FINAL} post_t;

  // top n bytes set, n in 0..8
  function automatic logic [63:0] top_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int j = 0; j < 8; j++) begin
      if (4'(j) < n) m[63-8*j -: 8] = 8'hff;
    end
    return m;
  endfunction

  // 10* pad byte at position n, n in 0..7
  function automatic logic [63:0] pad_bit(input logic [3:0] n);
    logic [63:0] p;
    p = '0;
    for (int j = 0; j < 8; j++) begin
      if (4'(j) == n) p[63-8*j -: 8] = 8'h80;
    end
    return p;
  endfunction

  state_t      state_r, state_nxt;
  phase_t      phase_r, phase_nxt;
  post_t       post_r, post_nxt;
  logic        dec_mode_r, dec_mode_nxt;
  logic [3:0]  rnd_r, rnd_nxt;
  lanes_t      lanes_r, lanes_nxt;
  logic [63:0] key_hi_r, key_hi_nxt, key_lo_r, key_lo_nxt;
  logic [63:0] exp_hi_r, exp_hi_nxt, exp_lo_r, exp_lo_nxt;

  // pending result
  logic        has_res_r, has_res_nxt;
  logic [63:0] res_word_r, res_word_nxt;
  logic [3:0]  res_bytes_r, res_bytes_nxt;
  logic        res_final_r, res_final_nxt;
  logic [63:0] res_th_r, res_th_nxt, res_tl_r, res_tl_nxt;
  logic        res_match_r, res_match_nxt;
  logic [1:0]  res_status_r, res_status_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_word_r, out_word_nxt;
  logic [3:0]  out_bytes_r, out_bytes_nxt;
  logic        out_final_r, out_final_nxt;
  logic [63:0] out_th_r, out_th_nxt, out_tl_r, out_tl_nxt;
  logic        out_match_r, out_match_nxt;
  logic [1:0]  out_status_r, out_status_nxt;

  lanes_t      round_out;
  logic        in_acc;
  logic        seq_err, count_err;
  logic [63:0] msk, din, x4a, th, tl;

  asc_round u_round (
    .lanes_in  (lanes_r),
    .rc        (round_const(rnd_r)),
    .lanes_out (round_out)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;

  // item checks
  always_comb begin
    case (in_kind)
      KIND_START: seq_err = 1'b0;
      KIND_AD:    seq_err = !(phase_r == PH_READY || phase_r == PH_AD);
      KIND_MSG:   seq_err = !(phase_r == PH_READY || phase_r == PH_MSG);
      default:    seq_err = 1'b1;
    endcase
    count_err = in_last ? (in_byte_count > BYTES_MAXL) : (in_byte_count != BYTES_FULL);
    msk       = top_mask(in_byte_count);
    din       = in_data_word & msk;
    x4a       = (phase_r == PH_READY) ? (lanes_r[4] ^ 64'd1) : lanes_r[4];
    th        = lanes_r[3] ^ key_hi_r;
    tl        = lanes_r[4] ^ key_lo_r;
  end

  // sequencer and datapath next state
  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    post_nxt       = post_r;
    dec_mode_nxt   = dec_mode_r;
    rnd_nxt        = rnd_r;
    lanes_nxt      = lanes_r;
    key_hi_nxt     = key_hi_r;
    key_lo_nxt     = key_lo_r;
    exp_hi_nxt     = exp_hi_r;
    exp_lo_nxt     = exp_lo_r;
    has_res_nxt    = has_res_r;
    res_word_nxt   = res_word_r;
    res_bytes_nxt  = res_bytes_r;
    res_final_nxt  = res_final_r;
    res_th_nxt     = res_th_r;
    res_tl_nxt     = res_tl_r;
    res_match_nxt  = res_match_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_word_nxt   = out_word_r;
    out_bytes_nxt  = out_bytes_r;
    out_final_nxt  = out_final_r;
    out_th_nxt     = out_th_r;
    out_tl_nxt     = out_tl_r;
    out_match_nxt  = out_match_r;
    out_status_nxt = out_status_r;

    // key writes
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_KEY_HIGH) key_hi_nxt = cfg_data;
      if (cfg_index == CFG_KEY_LOW)  key_lo_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          has_res_nxt    = 1'b0;
          res_word_nxt   = '0;
          res_bytes_nxt  = '0;
          res_final_nxt  = 1'b0;
          res_th_nxt     = '0;
          res_tl_nxt     = '0;
          res_match_nxt  = 1'b0;
          res_status_nxt = STATUS_OK;
          post_nxt       = POST_NONE;
          if (in_kind == KIND_START) begin
            lanes_nxt    = {in_extra_low, in_extra_high, key_lo_r, key_hi_r, ASC_IV};
            dec_mode_nxt = in_decrypt;
            phase_nxt    = PH_READY;
            post_nxt     = POST_START;
            rnd_nxt      = RND_FIRST_A;
            state_nxt    = S_RUN;
          end else if (seq_err) begin
            has_res_nxt    = 1'b1;
            res_status_nxt = STATUS_SEQ;
            state_nxt      = S_DONE;
          end else if (count_err) begin
            has_res_nxt    = 1'b1;
            res_status_nxt = STATUS_COUNT;
            state_nxt      = S_DONE;
          end else if (in_kind == KIND_AD) begin
            lanes_nxt[0] = lanes_r[0] ^ din ^ (in_last ? pad_bit(in_byte_count) : 64'd0);
            phase_nxt    = in_last ? PH_MSG : PH_AD;
            post_nxt     = in_last ? POST_ADLAST : POST_NONE;
            rnd_nxt      = RND_FIRST_B;
            state_nxt    = S_RUN;
          end else begin
            // message block: absorb or replace lane 0, emit output bytes
            has_res_nxt   = 1'b1;
            res_word_nxt  = (lanes_r[0] ^ din) & msk;
            res_bytes_nxt = in_byte_count;
            lanes_nxt[4]  = x4a;
            lanes_nxt[0]  = dec_mode_r ? ((lanes_r[0] & ~msk) | din) : (lanes_r[0] ^ din);
            if (in_last) begin
              lanes_nxt[0]  = lanes_nxt[0] ^ pad_bit(in_byte_count);
              lanes_nxt[1]  = lanes_r[1] ^ key_hi_r;
              lanes_nxt[2]  = lanes_r[2] ^ key_lo_r;
              res_final_nxt = 1'b1;
              exp_hi_nxt    = in_extra_high;
              exp_lo_nxt    = in_extra_low;
              post_nxt      = POST_FINAL;
              phase_nxt     = PH_IDLE;
              rnd_nxt       = RND_FIRST_A;
            end else begin
              phase_nxt     = PH_MSG;
              rnd_nxt       = RND_FIRST_B;
            end
            state_nxt = S_RUN;
          end
        end
      end
      // one round per cycle through the shared unit
      S_RUN: begin
        lanes_nxt = round_out;
        if (rnd_r == RND_LAST) begin
          state_nxt = S_POST;
        end else begin
          rnd_nxt = rnd_r + 4'd1;
        end
      end
      // key/domain fix-up or tag extraction after the permutation
      S_POST: begin
        case (post_r)
          POST_START: begin
            lanes_nxt[3] = lanes_r[3] ^ key_hi_r;
            lanes_nxt[4] = lanes_r[4] ^ key_lo_r;
          end
          POST_ADLAST: lanes_nxt[4] = lanes_r[4] ^ 64'd1;
          POST_FINAL: begin
            res_th_nxt    = th;
            res_tl_nxt    = tl;
            res_match_nxt = dec_mode_r && (th == exp_hi_r) && (tl == exp_lo_r);
          end
          default: ;
        endcase
        state_nxt = S_DONE;
      end
      // hand the result, if any, to the output register once it is free
      S_DONE: begin
        if (!has_res_r) begin
          state_nxt = S_IDLE;
        end else if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = res_word_r;
          out_bytes_nxt  = res_bytes_r;
          out_final_nxt  = res_final_r;
          out_th_nxt     = res_th_r;
          out_tl_nxt     = res_tl_r;
          out_match_nxt  = res_match_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      post_r      <= POST_NONE;
      dec_mode_r  <= 1'b0;
      rnd_r       <= '0;
      lanes_r     <= '0;
      key_hi_r    <= '0;
      key_lo_r    <= '0;
      has_res_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      post_r      <= post_nxt;
      dec_mode_r  <= dec_mode_nxt;
      rnd_r       <= rnd_nxt;
      lanes_r     <= lanes_nxt;
      key_hi_r    <= key_hi_nxt;
      key_lo_r    <= key_lo_nxt;
      has_res_r   <= has_res_nxt;
      out_valid_r <= out_valid_nxt;
    end
    exp_hi_r     <= exp_hi_nxt;
    exp_lo_r     <= exp_lo_nxt;
    res_word_r   <= res_word_nxt;
    res_bytes_r  <= res_bytes_nxt;
    res_final_r  <= res_final_nxt;
    res_th_r     <= res_th_nxt;
    res_tl_r     <= res_tl_nxt;
    res_match_r  <= res_match_nxt;
    res_status_r <= res_status_nxt;
    out_word_r   <= out_word_nxt;
    out_bytes_r  <= out_bytes_nxt;
    out_final_r  <= out_final_nxt;
    out_th_r     <= out_th_nxt;
    out_tl_r     <= out_tl_nxt;
    out_match_r  <= out_match_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_word      = out_word_r;
  assign out_bytes     = out_bytes_r;
  assign out_final_res = out_final_r;
  assign out_tag_high  = out_th_r;
  assign out_tag_low   = out_tl_r;
  assign out_tag_match = out_match_r;
  assign out_status    = out_status_r;

  // round counter never runs past the last round
  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> rnd_r <= RND_LAST)
    else $error("round counter out of range");

  // a start transaction launches a full permutation
  a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_kind == KIND_START |=> state_r == S_RUN && rnd_r == RND_FIRST_A)
    else $error("start did not launch twelve rounds");

  // last round is followed by the post step
  a_run_post: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN && rnd_r == RND_LAST |=> state_r == S_POST)
    else $error("sequencer skipped post step");

  // tag match only on a final, error-free result
  a_match_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tag_match |-> out_final_res && out_status == STATUS_OK)
    else $error("tag match outside final result");

  // a pending result is never dropped while the output is held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && has_res_r && out_valid_r && out_stall |=> state_r == S_DONE)
    else $error("result left done state while output stalled");

endmodule

// ----- tb/ascon128_aead_engine_tb.sv -----
// Self-checking testbench for ascon128_aead_engine: random and directed Ascon-128 sessions,
// checked against an in-bench sponge model of the permutation and the AEAD flow.
// Depends on asc_pkg and ascon128_aead_engine only.
module ascon128_aead_engine_tb;
  import asc_pkg::*;

  localparam logic [1:0]  KIND_ILLEGAL = 2'd3;
  localparam logic [63:0] SPONGE_IV    = 64'h80400c0600000000;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned HOLD_AFTER   = 320;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned SETTLE       = 20;

  typedef enum logic [1:0] {FLOW_IDLE, FLOW_READY, FLOW_AD, FLOW_MSG} flow_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        dec;
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
    logic [63:0] xh;
    logic [63:0] xl;
  } item_t;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  bytes;
    logic        fin;
    logic [63:0] th;
    logic [63:0] tl;
    logic        match;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    lanes_t      s;
    flow_t       st;
    logic        dec;
    logic [63:0] kh;
    logic [63:0] kl;
  } aead_ctx_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_kind;
  logic in_decrypt;
  logic [63:0] in_data_word;
  logic [3:0] in_byte_count;
  logic in_last;
  logic [63:0] in_extra_high;
  logic [63:0] in_extra_low;
  logic out_valid;
  logic out_stall;
  logic [63:0] out_word;
  logic [3:0] out_bytes;
  logic out_final_res;
  logic [63:0] out_tag_high;
  logic [63:0] out_tag_low;
  logic out_tag_match;
  logic [1:0] out_status;

  // predictor state, pending stimulus and outstanding expectations
  aead_ctx_t   engine_state;
  item_t       pending_q[$];
  result_t     expected_results[$];
  item_t       next_item;
  item_t       taken_item;
  result_t     predicted;
  result_t     oldest_result;
  logic        in_taken;
  int unsigned queued_items;
  int unsigned accepted_items;
  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned send_gap;
  int unsigned send_calm;
  int unsigned stall_left;
  int unsigned recv_calm;
  int unsigned hold_left;
  bit          hold_done;

  ascon128_aead_engine u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind), .in_decrypt(in_decrypt),
    .in_data_word(in_data_word), .in_byte_count(in_byte_count), .in_last(in_last),
    .in_extra_high(in_extra_high), .in_extra_low(in_extra_low),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word), .out_bytes(out_bytes),
    .out_final_res(out_final_res), .out_tag_high(out_tag_high), .out_tag_low(out_tag_low),
    .out_tag_match(out_tag_match), .out_status(out_status)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- sponge model
  function automatic logic [63:0] ror(input logic [63:0] v, input int n);
    return (v >> n) | (v << (64 - n));
  endfunction

  // last `rounds` rounds of the 12-round Ascon permutation
  function automatic lanes_t ascon_permute(input lanes_t s, input int rounds);
    logic [63:0] x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
    int r;
    {x4, x3, x2, x1, x0} = s;
    for (r = 12 - rounds; r < 12; r++) begin
      x2 ^= 64'(((15 - r) << 4) | r);
      x0 ^= x4; x4 ^= x3; x2 ^= x1;
      t0 = ~x0 & x1; t1 = ~x1 & x2; t2 = ~x2 & x3; t3 = ~x3 & x4; t4 = ~x4 & x0;
      x0 ^= t1; x1 ^= t2; x2 ^= t3; x3 ^= t4; x4 ^= t0;
      x1 ^= x0; x0 ^= x4; x3 ^= x2; x2 = ~x2;
      x0 ^= ror(x0, 19) ^ ror(x0, 28);
      x1 ^= ror(x1, 61) ^ ror(x1, 39);
      x2 ^= ror(x2, 1) ^ ror(x2, 6);
      x3 ^= ror(x3, 10) ^ ror(x3, 17);
      x4 ^= ror(x4, 7) ^ ror(x4, 41);
    end
    return {x4, x3, x2, x1, x0};
  endfunction

  // top n bytes of a big-endian block
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    if (n == 4'd0) return 64'd0;
    return ~64'd0 << (64 - 8 * int'(n));
  endfunction

  // 10* padding bit at byte n
  function automatic logic [63:0] pad_at(input logic [3:0] n);
    return 64'h80 << (56 - 8 * int'(n));
  endfunction

  function automatic bit bad_count(input item_t b);
    return b.last ? (b.count > BYTES_MAXL) : (b.count != BYTES_FULL);
  endfunction

  // one transaction through the AEAD flow; returns 1 when it yields a result
  function automatic bit aead_step(inout aead_ctx_t c, input item_t b, output result_t r);
    logic [63:0] m, d, res;
    r = '0;
    case (b.kind)
      KIND_START: begin
        c.s[0] = SPONGE_IV; c.s[1] = c.kh; c.s[2] = c.kl; c.s[3] = b.xh; c.s[4] = b.xl;
        c.s = ascon_permute(c.s, 12);
        c.s[3] ^= c.kh; c.s[4] ^= c.kl;
        c.dec = b.dec;
        c.st = FLOW_READY;
        return 1'b0;
      end
      KIND_AD: begin
        if (c.st != FLOW_READY && c.st != FLOW_AD) begin
          r.status = STATUS_SEQ;
          return 1'b1;
        end
        if (bad_count(b)) begin
          r.status = STATUS_COUNT;
          return 1'b1;
        end
        if (b.last) begin
          c.s[0] ^= (b.data & byte_mask(b.count)) ^ pad_at(b.count);
          c.s = ascon_permute(c.s, 6);
          c.s[4] ^= 64'd1;
          c.st = FLOW_MSG;
        end else begin
          c.s[0] ^= b.data;
          c.s = ascon_permute(c.s, 6);
          c.st = FLOW_AD;
        end
        return 1'b0;
      end
      KIND_MSG: begin
        if (c.st != FLOW_READY && c.st != FLOW_MSG) begin
          r.status = STATUS_SEQ;
          return 1'b1;
        end
        if (bad_count(b)) begin
          r.status = STATUS_COUNT;
          return 1'b1;
        end
        // empty associated data: domain separation happens here
        if (c.st == FLOW_READY) begin
          c.s[4] ^= 64'd1;
          c.st = FLOW_MSG;
        end
        m = byte_mask(b.count);
        d = b.data & m;
        if (!b.last) begin
          if (c.dec) begin
            res = c.s[0] ^ d;
            c.s[0] = d;
          end else begin
            c.s[0] ^= d;
            res = c.s[0];
          end
          c.s = ascon_permute(c.s, 6);
          r.word = res;
          r.bytes = BYTES_FULL;
          return 1'b1;
        end
        // partial final block: decrypt keeps the state bytes past the data
        if (c.dec) begin
          res = (c.s[0] ^ d) & m;
          c.s[0] = (c.s[0] & ~m) | d;
        end else begin
          c.s[0] ^= d;
          res = c.s[0] & m;
        end
        c.s[0] ^= pad_at(b.count);
        c.s[1] ^= c.kh; c.s[2] ^= c.kl;
        c.s = ascon_permute(c.s, 12);
        r.word = res;
        r.bytes = b.count;
        r.fin = 1'b1;
        r.th = c.s[3] ^ c.kh;
        r.tl = c.s[4] ^ c.kl;
        r.match = c.dec && r.th == b.xh && r.tl == b.xl;
        c.st = FLOW_IDLE;
        return 1'b1;
      end
      default: begin
        r.status = STATUS_SEQ;
        return 1'b1;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus helpers
  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic item_t make_item(input logic [1:0] kind, input logic dec,
                                      input logic [63:0] data, input logic [3:0] count,
                                      input logic last, input logic [63:0] xh,
                                      input logic [63:0] xl);
    item_t b;
    b.kind = kind; b.dec = dec; b.data = data; b.count = count;
    b.last = last; b.xh = xh; b.xl = xl;
    return b;
  endfunction

  // mostly short idles, a few long ones, and idle-free stretches now and then
  function automatic int unsigned idle_len(inout int unsigned calm);
    int unsigned p;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(49) == 0) calm = $urandom_range(60, 20);
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 88) return $urandom_range(3, 1);
    if (p < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic push_item(input item_t b);
    pending_q.push_back(b);
    queued_items++;
  endtask

  // always turned away, whatever the phase
  function automatic item_t rejected_item();
    logic [1:0] k;
    k = $urandom_range(1) ? KIND_AD : KIND_MSG;
    case ($urandom_range(2))
      0: return make_item(KIND_ILLEGAL, 1'($urandom_range(1)), rand64(),
                          4'($urandom_range(8)), 1'($urandom_range(1)), rand64(), rand64());
      1: return make_item(k, 1'($urandom_range(1)), rand64(), 4'($urandom_range(7)), 1'b0,
                          rand64(), rand64());
      default: return make_item(k, 1'($urandom_range(1)), rand64(), BYTES_FULL, 1'b1,
                                rand64(), rand64());
    endcase
  endfunction

  // a session with random content, cut short when broken; decrypt runs replay the ciphertext of an
  // encryption under the same key and nonce, with the true tag or a corrupted one
  task automatic queue_session(input bit decrypt_run, input bit honest_tag, input bit broken);
    item_t blocks[$];
    item_t blk;
    aead_ctx_t scratch;
    result_t r;
    int unsigned n_full, j, keep;
    blocks.push_back(make_item(KIND_START, 1'b0, rand64(), 4'($urandom_range(8)),
                               1'($urandom_range(1)), rand64(), rand64()));
    if ($urandom_range(9) > 3) begin
      n_full = ($urandom_range(7) == 0) ? 3 : $urandom_range(2);
      repeat (n_full)
        blocks.push_back(make_item(KIND_AD, 1'($urandom_range(1)), rand64(), BYTES_FULL, 1'b0,
                                   rand64(), rand64()));
      blocks.push_back(make_item(KIND_AD, 1'($urandom_range(1)), rand64(),
                                 4'($urandom_range(7)), 1'b1, rand64(), rand64()));
    end
    n_full = ($urandom_range(9) == 0) ? $urandom_range(6, 3) : $urandom_range(2);
    repeat (n_full)
      blocks.push_back(make_item(KIND_MSG, 1'($urandom_range(1)), rand64(), BYTES_FULL, 1'b0,
                                 rand64(), rand64()));
    blocks.push_back(make_item(KIND_MSG, 1'($urandom_range(1)), rand64(),
                               4'($urandom_range(7)), 1'b1, rand64(), rand64()));

    scratch = '0;
    scratch.kh = engine_state.kh;
    scratch.kl = engine_state.kl;
    for (j = 0; j < blocks.size(); j++) begin
      blk = blocks[j];
      if (aead_step(scratch, blk, r) && decrypt_run) begin
        blk.data = r.word | (rand64() & ~byte_mask(blk.count));
        if (blk.last) begin
          blk.xh = r.th;
          blk.xl = r.tl;
          if (!honest_tag) begin
            if ($urandom_range(1)) blk.xh ^= 64'd1 << $urandom_range(63);
            else blk.xl ^= 64'd1 << $urandom_range(63);
          end
        end
        blocks[j] = blk;
      end
    end
    blk = blocks[0];
    blk.dec = decrypt_run;
    blocks[0] = blk;

    if (!broken && $urandom_range(4) == 0)
      blocks.insert($urandom_range(blocks.size() - 1, 1), rejected_item());
    keep = broken ? $urandom_range(blocks.size() - 1, 1) : blocks.size();
    for (j = 0; j < keep; j++) push_item(blocks[j]);
  endtask

  task automatic queue_random(input int unsigned target);
    int unsigned first, p;
    first = queued_items;
    while (queued_items - first < target) begin
      p = $urandom_range(99);
      if (p < 35) queue_session(1'b0, 1'b1, 1'b0);
      else if (p < 60) queue_session(1'b1, 1'b1, 1'b0);
      else if (p < 70) queue_session(1'b1, 1'b0, 1'b0);
      else if (p < 80) queue_session(1'($urandom_range(1)), 1'b1, 1'b1);
      else push_item(make_item(2'($urandom_range(3)), 1'($urandom_range(1)), rand64(),
                               4'($urandom_range(8)), 1'($urandom_range(1)), rand64(), rand64()));
    end
  endtask

  task automatic queue_directed();
    logic [63:0] ones;
    ones = ~64'd0;
    // while idle, every item but a start is rejected with a sequence error
    push_item(make_item(KIND_MSG, 1'b0, ones, 4'd0, 1'b1, 64'd0, 64'd0));
    push_item(make_item(KIND_AD, 1'b1, ones, BYTES_FULL, 1'b0, ones, ones));
    push_item(make_item(KIND_ILLEGAL, 1'b1, ones, BYTES_FULL, 1'b1, ones, ones));
    // empty AD and empty message
    push_item(make_item(KIND_START, 1'b0, ones, BYTES_FULL, 1'b1, 64'd0, 64'd0));
    push_item(make_item(KIND_MSG, 1'b0, 64'd0, 4'd0, 1'b1, 64'd0, 64'd0));
    // decrypt session with bad counts, pad-only AD block and a late AD block
    push_item(make_item(KIND_START, 1'b1, 64'd0, 4'd0, 1'b0, ones, ones));
    push_item(make_item(KIND_AD, 1'b0, ones, BYTES_MAXL, 1'b0, 64'd0, 64'd0));
    push_item(make_item(KIND_AD, 1'b0, ones, BYTES_FULL, 1'b1, 64'd0, 64'd0));
    push_item(make_item(KIND_AD, 1'b0, ones, BYTES_FULL, 1'b0, 64'd0, 64'd0));
    push_item(make_item(KIND_AD, 1'b0, ones, 4'd0, 1'b1, 64'd0, 64'd0));
    push_item(make_item(KIND_AD, 1'b0, ones, BYTES_FULL, 1'b0, 64'd0, 64'd0));
    push_item(make_item(KIND_MSG, 1'b0, ones, 4'd0, 1'b0, 64'd0, 64'd0));
    push_item(make_item(KIND_MSG, 1'b0, ones, BYTES_FULL, 1'b0, 64'd0, 64'd0));
    push_item(make_item(KIND_MSG, 1'b1, ones, BYTES_MAXL, 1'b1, ones, ones));
    // message while AD is open, then a restart in mid-AD
    push_item(make_item(KIND_START, 1'b0, 64'd0, 4'd0, 1'b0, rand64(), rand64()));
    push_item(make_item(KIND_AD, 1'b0, rand64(), BYTES_FULL, 1'b0, 64'd0, 64'd0));
    push_item(make_item(KIND_MSG, 1'b0, rand64(), BYTES_FULL, 1'b0, 64'd0, 64'd0));
    push_item(make_item(KIND_START, 1'b0, 64'd0, 4'd0, 1'b0, rand64(), rand64()));
    push_item(make_item(KIND_AD, 1'b0, rand64(), 4'd3, 1'b1, 64'd0, 64'd0));
    push_item(make_item(KIND_MSG, 1'b0, 64'd0, 4'd5, 1'b1, 64'd0, 64'd0));
    // round trip that must authenticate
    queue_session(1'b1, 1'b1, 1'b0);
  endtask

  // ---------------------------------------------------------------- configuration
  task automatic write_cfg_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_KEY_HIGH) engine_state.kh = val;
    else engine_state.kl = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
    write_cfg_reg(CFG_KEY_HIGH, hi);
    write_cfg_reg(CFG_KEY_LOW, lo);
  endtask

  // sender stops until every result is back and the engine has gone quiet
  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic compare_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endtask

  // ---------------------------------------------------------------- input driver
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        next_item = pending_q.pop_front();
        in_kind <= next_item.kind;
        in_decrypt <= next_item.dec;
        in_data_word <= next_item.data;
        in_byte_count <= next_item.count;
        in_last <= next_item.last;
        in_extra_high <= next_item.xh;
        in_extra_low <= next_item.xl;
        in_valid <= 1'b1;
        send_gap = idle_len(send_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- result back-pressure
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && accepted_items >= HOLD_AFTER) begin
      // one long hold-off so the engine backs up into its input
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = idle_len(recv_calm);
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // ---------------------------------------------------------------- monitor and predictor
  always @(posedge clk) begin
    cycle_count++;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, word %h status %0d", $time, out_word,
                   out_status);
        end else begin
          oldest_result = expected_results.pop_front();
          compare_field("out_word", oldest_result.word, out_word);
          compare_field("out_bytes", 64'(oldest_result.bytes), 64'(out_bytes));
          compare_field("out_final_res", 64'(oldest_result.fin), 64'(out_final_res));
          compare_field("out_tag_high", oldest_result.th, out_tag_high);
          compare_field("out_tag_low", oldest_result.tl, out_tag_low);
          compare_field("out_tag_match", 64'(oldest_result.match), 64'(out_tag_match));
          compare_field("out_status", 64'(oldest_result.status), 64'(out_status));
        end
      end
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        accepted_items++;
        taken_item = make_item(in_kind, in_decrypt, in_data_word, in_byte_count, in_last,
                               in_extra_high, in_extra_low);
        if (aead_step(engine_state, taken_item, predicted))
          expected_results.push_back(predicted);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------- sequence of phases
  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_kind = KIND_START;
    in_decrypt = 1'b0;
    in_data_word = '0;
    in_byte_count = '0;
    in_last = 1'b0;
    in_extra_high = '0;
    in_extra_low = '0;
    out_stall = 1'b0;
    in_taken = 1'b0;
    engine_state = '0;
    queued_items = 0;
    accepted_items = 0;
    cycle_count = 0;
    mismatches = 0;
    send_gap = 0;
    send_calm = 0;
    stall_left = 0;
    recv_calm = 0;
    hold_left = 0;
    hold_done = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_key(64'd0, 64'd0);
    queue_directed();
    wait_drained();

    write_key(~64'd0, ~64'd0);
    queue_random(150);
    wait_drained();

    // the long receiver hold-off falls in this phase
    write_key(rand64(), rand64());
    queue_random(300);
    wait_drained();

    write_key(~64'd0, 64'd0);
    queue_random(150);
    wait_drained();

    write_key(rand64(), rand64());
    queue_random(150);
    wait_drained();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/asc_pkg.sv
rtl/asc_round.sv
rtl/ascon128_aead_engine.sv
tb/ascon128_aead_engine_tb.sv
